FILE: rtl/core/slsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slsp_pkg
// Types and character codes shared by the shell line splitter.
// ----------------------------------------------------------------------------
package slsp_pkg;

	typedef enum logic [2:0] {
		MODE_PLAIN   = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_SQUOTE  = 3'd2,
		MODE_ESCAPE  = 3'd3,
		MODE_DOLLAR  = 3'd4,
		MODE_BRACE   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		KIND_CHAR   = 2'd0,
		KIND_LINE   = 2'd1,
		KIND_NOLINE = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_char;
		logic       hanging;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} lex_out_t;

endpackage
`default_nettype wire

FILE: rtl/core/slsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slsp_if
// Valid/ready channels for input characters and result words.
// ----------------------------------------------------------------------------
interface slsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_input;

	modport source (output valid, output ch, output end_of_input, input ready);
	modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface slsp_out_if;
	import slsp_pkg::*;

	logic       valid;
	logic       ready;
	kind_t      kind;
	logic [7:0] out_char;
	logic       hanging;
	logic       last;

	modport source (output valid, output kind, output out_char, output hanging,
		output last, input ready);
	modport sink   (input valid, input kind, input out_char, input hanging,
		input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/slsp_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slsp_lexer
// Lexer mode state and the zero to two result words for each accepted item.
// ----------------------------------------------------------------------------
module slsp_lexer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        ch,
	input  wire logic              end_of_input,
	output slsp_pkg::lex_out_t     lex
);
	import slsp_pkg::*;

	mode_t mode_q, mode_n;
	logic  dq_q, dq_n;
	logic  has_q, has_n;
	logic  hang_q, hang_n;

	function automatic result_t mk(kind_t k, logic [7:0] c, logic h, logic l);
		result_t r;
		r.kind     = k;
		r.out_char = c;
		r.hanging  = h;
		r.last     = l;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			dq_q   <= 1'b0;
			has_q  <= 1'b0;
			hang_q <= 1'b0;
		end else begin
			mode_q <= mode_n;
			dq_q   <= dq_n;
			has_q  <= has_n;
			hang_q <= hang_n;
		end
	end

	always_comb begin
		mode_n = mode_q;
		dq_n   = dq_q;
		has_n  = has_q;
		hang_n = hang_q;
		lex    = '0;
		if (accept) begin
			if (end_of_input) begin
				lex.count = 2'd1;
				case (mode_q)
					MODE_SQUOTE, MODE_BRACE: begin
						lex.first = mk(KIND_ERROR, 8'h00, 1'b1, 1'b1);
					end
					MODE_ESCAPE: begin
						lex.count  = 2'd2;
						lex.first  = mk(KIND_CHAR, CH_BSLASH, dq_q, 1'b0);
						lex.second = mk(KIND_LINE, 8'h00, dq_q, 1'b1);
					end
					default: begin
						lex.first = mk(has_q ? KIND_LINE : KIND_NOLINE, 8'h00, dq_q, 1'b1);
					end
				endcase
				mode_n = MODE_PLAIN;
				dq_n   = 1'b0;
				has_n  = 1'b0;
				hang_n = 1'b0;
			end else begin
				has_n = 1'b1;
				case (mode_q)
					MODE_COMMENT: begin
						if (ch == CH_NL) mode_n = MODE_PLAIN;
					end
					MODE_SQUOTE: begin
						if (ch == CH_SQUOTE) begin
							mode_n = MODE_PLAIN;
							hang_n = dq_q;
						end
						lex.count = 2'd1;
						lex.first = mk(KIND_CHAR, ch, hang_n, 1'b1);
					end
					MODE_ESCAPE: begin
						mode_n = MODE_PLAIN;
						hang_n = dq_q;
						if (ch != CH_NL) begin
							lex.count  = 2'd2;
							lex.first  = mk(KIND_CHAR, CH_BSLASH, dq_q, 1'b0);
							lex.second = mk(KIND_CHAR, ch, dq_q, 1'b1);
						end
					end
					MODE_DOLLAR: begin
						if (ch == CH_LBRACE) begin
							mode_n = MODE_BRACE;
						end else begin
							mode_n = MODE_PLAIN;
							hang_n = dq_q;
						end
						lex.count = 2'd1;
						lex.first = mk(KIND_CHAR, ch, hang_n, 1'b1);
					end
					MODE_BRACE: begin
						if (ch == CH_RBRACE) begin
							mode_n = MODE_PLAIN;
							hang_n = dq_q;
						end
						lex.count = 2'd1;
						lex.first = mk(KIND_CHAR, ch, hang_n, 1'b1);
					end
					default: begin
						mode_n = MODE_PLAIN;
						if (ch == CH_HASH && !dq_q) begin
							mode_n = MODE_COMMENT;
						end else if (ch == CH_NL && !dq_q) begin
							lex.count = 2'd1;
							lex.first = mk(KIND_LINE, 8'h00, 1'b0, 1'b1);
							dq_n      = 1'b0;
							has_n     = 1'b0;
							hang_n    = 1'b0;
						end else if (ch == CH_BSLASH) begin
							mode_n = MODE_ESCAPE;
							hang_n = 1'b1;
						end else begin
							if (ch == CH_DQUOTE) begin
								dq_n   = ~dq_q;
								hang_n = ~dq_q;
							end else if (ch == CH_SQUOTE && !dq_q) begin
								mode_n = MODE_SQUOTE;
								hang_n = 1'b1;
							end else if (ch == CH_DOLLAR) begin
								mode_n = MODE_DOLLAR;
								hang_n = 1'b1;
							end
							lex.count = 2'd1;
							lex.first = mk(KIND_CHAR, ch, hang_n, 1'b1);
						end
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/shell_line_splitter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shell_line_splitter_top
// Splits a character stream into shell command lines.
// Results: the result words of an accepted item are registered into the
// result queue and offered in order from its head.
// Throughput: one item per cycle while the result queue holds fewer than
// two words; the three-word queue gives out one word a cycle when ready.
// Reset: asynchronous, clears lexer state and empties the result queue.
// ----------------------------------------------------------------------------
module shell_line_splitter_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	slsp_in_if.sink    chars,
	slsp_out_if.source results
);
	import slsp_pkg::*;

	lex_out_t   lex;
	result_t    q_q [3];
	result_t    q_n [3];
	logic [1:0] cnt_q;
	logic [1:0] cnt_n;
	logic [1:0] base;
	logic       acc;
	logic       pop;

	assign chars.ready = !cnt_q[1];
	assign acc         = chars.valid && chars.ready;
	assign pop         = results.valid && results.ready;

	slsp_lexer u_lexer (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (acc),
		.ch           (chars.ch),
		.end_of_input (chars.end_of_input),
		.lex          (lex)
	);

	always_comb begin
		q_n  = q_q;
		if (pop) begin
			q_n[0] = q_q[1];
			q_n[1] = q_q[2];
		end
		base = cnt_q - {1'b0, pop};
		for (int i = 0; i < 3; i++) begin
			if (lex.count != 2'd0 && base == 2'(i)) q_n[i] = lex.first;
			if (lex.count == 2'd2 && (base + 2'd1) == 2'(i)) q_n[i] = lex.second;
		end
		cnt_n = base + lex.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		q_q <= q_n;
	end

	assign results.valid    = cnt_q != 2'd0;
	assign results.kind     = q_q[0].kind;
	assign results.out_char = q_q[0].out_char;
	assign results.hanging  = q_q[0].hanging;
	assign results.last     = q_q[0].last;

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ({1'b0, cnt_q} - {2'b0, pop} + {1'b0, lex.count}) <= 3'd3)
		else $error("result queue overflow");

	a_eoi: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && chars.end_of_input) |-> lex.count != 2'd0)
		else $error("end of input gave no result");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && lex.count == 2'd2) |-> (!lex.first.last && lex.second.last))
		else $error("last flag misplaced on word pair");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && results.kind != KIND_CHAR) |-> results.last)
		else $error("line end word not marked last");

endmodule
`default_nettype wire
